/* hw/rtl/lpd_pkg.sv */
// Shared types and constants for the length prefix deframer.
`default_nettype none
package lpd_pkg;

	// Header size in bytes; also the lowest length ever accepted
	localparam logic [15:0] HDR_LEN = 16'd2;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Register indexes on the configuration port
	localparam logic REG_MIN_LENGTH = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DATA  = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	// Parser phase
	typedef enum logic [1:0] {
		PH_LOW    = 2'd0,
		PH_HIGH   = 2'd1,
		PH_BODY   = 2'd2,
		PH_FAILED = 2'd3
	} phase_t;

	// One classified input word handed from front to back.
	// pair: emit lo_byte (first of packet) and then data_byte.
	typedef struct packed {
		logic       pair;
		logic [7:0] lo_byte;
		logic [7:0] data_byte;
		logic       last;
		logic [1:0] status;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/lpd_front.sv */
// Front end: tracks packet framing and classifies each received byte.
`default_nettype none
module lpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [15:0]   min_length,
	input  wire logic [15:0]   max_length,
	output      logic          cmd_push,
	output      lpd_pkg::cmd_t cmd
);

	lpd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [15:0] len_q, len_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] len_w;
	logic [15:0] eff_min;
	logic [15:0] seen_inc;

	assign len_w    = {rx_byte, held_q};
	assign eff_min  = (min_length < lpd_pkg::HDR_LEN) ? lpd_pkg::HDR_LEN : min_length;
	assign seen_inc = seen_q + 16'd1;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpd_pkg::PH_LOW;
			held_q  <= '0;
			len_q   <= '0;
			seen_q  <= '0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
		end
	end

	// Next state and command
	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		len_d    = len_q;
		seen_d   = seen_q;
		cmd_push = 1'b0;
		cmd      = '0;
		if (accept) begin
			unique case (phase_q)
				lpd_pkg::PH_LOW: begin
					held_d  = rx_byte;
					phase_d = lpd_pkg::PH_HIGH;
				end
				lpd_pkg::PH_HIGH: begin
					len_d    = len_w;
					cmd_push = 1'b1;
					if (len_w < eff_min) begin
						cmd.status = lpd_pkg::ST_SHORT;
						phase_d    = lpd_pkg::PH_FAILED;
					end else if (len_w > max_length) begin
						cmd.status = lpd_pkg::ST_LONG;
						phase_d    = lpd_pkg::PH_FAILED;
					end else begin
						cmd.pair      = 1'b1;
						cmd.lo_byte   = held_q;
						cmd.data_byte = rx_byte;
						cmd.last      = (len_w == lpd_pkg::HDR_LEN);
						cmd.status    = lpd_pkg::ST_DATA;
						seen_d        = lpd_pkg::HDR_LEN;
						phase_d       = cmd.last ? lpd_pkg::PH_LOW : lpd_pkg::PH_BODY;
					end
				end
				lpd_pkg::PH_BODY: begin
					seen_d        = seen_inc;
					cmd_push      = 1'b1;
					cmd.data_byte = rx_byte;
					cmd.last      = (seen_inc >= len_q);
					cmd.status    = lpd_pkg::ST_DATA;
					if (cmd.last) begin
						phase_d = lpd_pkg::PH_LOW;
					end
				end
				lpd_pkg::PH_FAILED: begin
					// dropped until reset
				end
				default: begin
					phase_d = lpd_pkg::PH_FAILED;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lpd_queue.sv */
// Short command queue between the front and back ends.
`default_nettype none
module lpd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lpd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output      lpd_pkg::cmd_t head,
	output      logic          empty,
	output      logic          full
);

	lpd_pkg::cmd_t slot_q [lpd_pkg::QDEPTH];
	logic [lpd_pkg::QAW-1:0] wr_q, rd_q;
	logic [lpd_pkg::QAW:0]   cnt_q;
	logic do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (lpd_pkg::QAW+1)'(lpd_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lpd_back.sv */
// Back end: expands commands into result words in an output register.
`default_nettype none
module lpd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lpd_pkg::cmd_t head,
	input  wire logic          q_empty,
	output      logic          q_pop,
	input  wire logic          pop,
	output      logic          empty,
	output      logic [7:0]    pkt_byte,
	output      logic          pkt_first,
	output      logic          pkt_last,
	output      logic [1:0]    status
);

	logic       out_vld_q;
	logic       half_q;
	logic [7:0] byte_q;
	logic       first_q, last_q;
	logic [1:0] status_q;
	logic       load;
	logic       emit_lo;

	// Output slot free, or being taken this cycle
	assign load    = !q_empty && (!out_vld_q || pop);
	assign emit_lo = head.pair && !half_q;
	assign q_pop   = load && !emit_lo;

	assign empty     = !out_vld_q;
	assign pkt_byte  = byte_q;
	assign pkt_first = first_q;
	assign pkt_last  = last_q;
	assign status    = status_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			half_q    <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				half_q    <= emit_lo;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_lo) begin
				byte_q   <= head.lo_byte;
				first_q  <= 1'b1;
				last_q   <= 1'b0;
				status_q <= lpd_pkg::ST_DATA;
			end else begin
				byte_q   <= head.data_byte;
				first_q  <= 1'b0;
				last_q   <= head.last;
				status_q <= head.status;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/length_prefix_deframer.sv */
// Top level of the length prefix deframer: config registers and the front/back split.
//
//   channel   | handshake          | words
//   ----------+--------------------+------------------------------------------
//   input     | push / full        | rx_byte
//   result    | empty / pop        | pkt_byte, pkt_first, pkt_last, status
//   config    | psel/penable/pwrite| min_length @0x0, max_length @0x4
//
// The front takes one byte per cycle while the 4-entry command queue has room.
// The back drives one result word per cycle from its output register while pop
// keeps taking them; a valid header gives two words from one queue entry.
// Reset clears the parser to await the length low byte and empties the queue.
// A stalled result side backs up through the queue to full.
`default_nettype none
module length_prefix_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [7:0]  rx_byte,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [7:0]  pkt_byte,
	output      logic        pkt_first,
	output      logic        pkt_last,
	output      logic [1:0]  status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	logic [15:0]   min_q, max_q;
	logic          cfg_wr;
	logic          accept;
	logic          cmd_push;
	lpd_pkg::cmd_t cmd;
	lpd_pkg::cmd_t head;
	logic          q_empty, q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = push && !full;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'd2;
			max_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lpd_pkg::REG_MIN_LENGTH: min_q <= pwdata[15:0];
				lpd_pkg::REG_MAX_LENGTH: max_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (paddr[2])
			lpd_pkg::REG_MIN_LENGTH: prdata = {16'd0, min_q};
			lpd_pkg::REG_MAX_LENGTH: prdata = {16'd0, max_q};
			default:                 prdata = '0;
		endcase
	end

	lpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.min_length (min_q),
		.max_length (max_q),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	lpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty),
		.full     (full)
	);

	lpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.pkt_byte  (pkt_byte),
		.pkt_first (pkt_first),
		.pkt_last  (pkt_last),
		.status    (status)
	);

endmodule
`default_nettype wire
